// ===== hw/rtl/fgh_pkg.sv =====
package fgh_pkg;

  // Field widths
  localparam int POS_W  = 10;
  localparam int SIZE_W = 11;
  localparam int CTR_W  = 12;
  localparam int RAD_W  = 13;
  localparam int CONF_W = 16;
  localparam int EXP_W  = 17;
  localparam int HEAT_W = 16;
  localparam int FCNT_W = 5;

  // Datapath widths
  localparam int MUL_AW = 32;
  localparam int MUL_BW = 24;
  localparam int PROD_W = MUL_AW + MUL_BW;
  localparam int DIV_W  = 50;
  localparam int LO_W   = 30;
  localparam int SQ_W   = 28;

  // Step counts of the shared divider and top bit index of the root unit
  localparam int CONF_DIV_STEPS = 30;
  localparam int HEAT_DIV_STEPS = 17;
  localparam int SQRT_TOP       = 13;

  localparam logic [CONF_W-1:0] CONF_ONE   = 16'd32768;
  localparam logic [CONF_W-1:0] CONF_FLOOR = 16'd19661;
  localparam logic [HEAT_W-1:0] HEAT_MAX   = 16'hFFFF;
  localparam logic [63:0]       Q31_ONE    = 64'd1 << 31;

  // Parameter defaults
  localparam int MAX_FACES_DEF       = 16;
  localparam int COORD_BITS_DEF      = 10;
  localparam int EXP_TABLE_DEPTH_DEF = 256;

  // Register reset values
  localparam logic [SIZE_W-1:0] FRAME_W_RST = 11'd320;
  localparam logic [SIZE_W-1:0] FRAME_H_RST = 11'd240;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ENABLE       = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0] box_width;
    logic [SIZE_W-1:0] box_height;
  } in_word_t;

  typedef struct packed {
    logic [HEAT_W-1:0] heat;
    logic [FCNT_W-1:0] face_count;
    logic              list_full;
  } out_word_t;

  typedef struct packed {
    logic [CTR_W-1:0]  cx;
    logic [CTR_W-1:0]  cy;
    logic [RAD_W-1:0]  rad;
    logic [CONF_W-1:0] conf;
  } face_t;

  // exp(-f), f in Q1.31, 0 <= f <= 1
  function automatic logic [63:0] exp_frac(logic [63:0] f);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = Q31_ONE;
    term = Q31_ONE;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * f) >> 31) / 64'(n);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Table entry for argument x in Q1.31 (x < 16), rounded to Q1.16
  function automatic logic [EXP_W-1:0] exp_entry(logic [63:0] x);
    logic [63:0] e1;
    logic [63:0] ei;
    logic [63:0] v;
    logic [63:0] fp;
    logic [4:0]  ip;
    e1 = exp_frac(Q31_ONE);
    ip = x[35:31];
    fp = {33'd0, x[30:0]};
    ei = Q31_ONE;
    for (int j = 0; j < 16; j++) begin
      if (5'(j) < ip) begin
        ei = (ei * e1) >> 31;
      end
    end
    v = (ei * exp_frac(fp)) >> 31;
    return EXP_W'((v + (64'd1 << 14)) >> 15);
  endfunction

endpackage

// ===== hw/rtl/face_gaussian_heatmap.sv =====
// Face heat map.
// Input channel (in_valid/in_stall/in_data) carries one word per command:
// clear the face list, add a face box, or query the heat at one pixel.
// Every word yields exactly one result word on the output channel
// (out_valid/out_stall/out_data): heat (Q0.16), face count, list-full flag.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) sets frame width,
// frame height and enable; cfg_ready is always high. Write it only when idle.
// One word at a time: in_stall stays high until its result is loaded into
// the output register.
// Work per word, set by the shared sequencer:
//   clear, unused mode, add to a full list, disabled or empty query: no arithmetic
//   add: 7 multiplies, 30 divide steps and 14 root steps, or the multiplies
//   alone when the box center lies far enough out that the confidence floors
//   query: for each face a read, multiplies and a table divide, a face out
//   of the table's reach skipping the divide; one face read per pass.
// The result sits in an output register; when the receiver stalls it holds
// and the next word may still be accepted and worked on, finishing only
// once the output register is free.
// Reset empties the face list and loads width 320, height 240, enable 1.
// The face memory needs no clearing: only entries below the count are read.
module face_gaussian_heatmap #(
  parameter int MAX_FACES       = fgh_pkg::MAX_FACES_DEF,
  parameter int COORD_BITS      = fgh_pkg::COORD_BITS_DEF,
  parameter int EXP_TABLE_DEPTH = fgh_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  fgh_pkg::in_word_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output fgh_pkg::out_word_t        out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [fgh_pkg::SIZE_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_FACES + 1);
  localparam int IDX_W = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int QB    = $clog2(EXP_TABLE_DEPTH);
  localparam int POS_W = fgh_pkg::POS_W;
  localparam int SZ_W  = fgh_pkg::SIZE_W;
  localparam int CTR_W = fgh_pkg::CTR_W;
  localparam int RAD_W = fgh_pkg::RAD_W;
  localparam int CF_W  = fgh_pkg::CONF_W;
  localparam int PR_W  = fgh_pkg::PROD_W;
  localparam int DV_W  = fgh_pkg::DIV_W;
  localparam int LO_W  = fgh_pkg::LO_W;
  localparam int SQ_W  = fgh_pkg::SQ_W;
  localparam int BEST_W = 33;
  localparam logic [POS_W-1:0] POS_MASK =
    (COORD_BITS >= POS_W) ? {POS_W{1'b1}} : POS_W'((1 << COORD_BITS) - 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_C_SQX, ST_C_SQY, ST_C_W2, ST_C_H2, ST_C_NH, ST_C_NW, ST_C_WH,
    ST_C_DEN, ST_C_CHK, ST_SQ_INIT, ST_SQ, ST_C_CONF, ST_C_STORE,
    ST_Q_RD, ST_Q_SQX, ST_Q_SQY, ST_Q_R2, ST_Q_ND, ST_Q_DCHK, ST_Q_EXP,
    ST_Q_CMP, ST_Q_NEXT, ST_F_SAT, ST_DIV, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_CONF, PH_EXP, PH_HEAT
  } phase_t;

  // Exp table, built at elaboration
  logic [fgh_pkg::EXP_W-1:0] exp_tab [EXP_TABLE_DEPTH];
  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_exp
    localparam logic [63:0] XK = ((64'(k) * 64'd16) << 31) / EXP_TABLE_DEPTH;
    assign exp_tab[k] = fgh_pkg::exp_entry(XK);
  end

  fgh_pkg::face_t face_mem [MAX_FACES];

  state_t              state_r;
  phase_t              phase_r;
  logic                out_valid_r;
  fgh_pkg::out_word_t  out_data_r;
  logic [SZ_W-1:0]     fw_r, fh_r;
  logic                en_r;
  logic [CNT_W-1:0]    count_r;
  logic [CF_W-1:0]     peak_r;
  logic [POS_W-1:0]    px_r, py_r;
  logic [CTR_W-1:0]    cx_r, cy_r;
  logic [RAD_W-1:0]    rad_r;
  logic [11:0]         ax_r, ay_r;
  logic [SZ_W-1:0]     wq_r, hq_r;
  logic [23:0]         nx2_r, ny2_r;
  logic [21:0]         w2_r, h2_r;
  logic [45:0]         numa_r;
  logic [46:0]         num_r;
  logic [43:0]         den_r;
  logic [PR_W-1:0]     prod_r;
  logic [DV_W-1:0]     rem_r, dden_r;
  logic [LO_W-1:0]     lo_r, q_r;
  logic [4:0]          cnt_r;
  logic [SQ_W-1:0]     sqv_r, sqr_r;
  logic [3:0]          sqk_r;
  logic [IDX_W-1:0]    idx_r;
  fgh_pkg::face_t      rd_r;
  logic [24:0]         d2_r;
  logic [27:0]         qden_r;
  logic [CF_W-1:0]     conf_r;
  logic [BEST_W-1:0]   best_r;
  logic [fgh_pkg::HEAT_W-1:0] heat_r;
  logic                full_r;

  // Shared multiplier operands
  logic [fgh_pkg::MUL_AW-1:0] mul_a;
  logic [fgh_pkg::MUL_BW-1:0] mul_b;

  // Accept-time values
  logic [POS_W-1:0] px_m, py_m;
  logic [SZ_W-1:0]  bw_e, bh_e, fw_e, fh_e, bmax;
  logic signed [13:0] nx_s, ny_s;
  logic [13:0]      nx_a, ny_a;
  logic             accept;

  // Query distances and divider step
  logic signed [CTR_W:0] dx_s, dy_s;
  logic [CTR_W:0]   dx_a, dy_a;
  logic [DV_W-1:0]  div_t;
  logic             div_ge;
  logic [SQ_W-1:0]  sq_bit, sq_sum;
  logic [CF_W:0]    conf_raw;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    px_m = in_data.pos_x & POS_MASK;
    py_m = in_data.pos_y & POS_MASK;
    bw_e = (in_data.box_width == '0) ? SZ_W'(1) : in_data.box_width;
    bh_e = (in_data.box_height == '0) ? SZ_W'(1) : in_data.box_height;
    fw_e = (fw_r == '0) ? SZ_W'(1) : fw_r;
    fh_e = (fh_r == '0) ? SZ_W'(1) : fh_r;
    bmax = (bw_e > bh_e) ? bw_e : bh_e;
    nx_s = $signed({3'd0, px_m, 1'b0}) + $signed({3'd0, bw_e})
         - $signed({3'd0, fw_e[SZ_W-1:1], 1'b0});
    ny_s = $signed({3'd0, py_m, 1'b0}) + $signed({3'd0, bh_e})
         - $signed({3'd0, fh_e[SZ_W-1:1], 1'b0});
    nx_a = nx_s[13] ? 14'(-nx_s) : 14'(nx_s);
    ny_a = ny_s[13] ? 14'(-ny_s) : 14'(ny_s);
  end

  always_comb begin
    dx_s = $signed({3'd0, px_r}) - $signed({1'b0, rd_r.cx});
    dy_s = $signed({3'd0, py_r}) - $signed({1'b0, rd_r.cy});
    dx_a = dx_s[CTR_W] ? (CTR_W+1)'(-dx_s) : (CTR_W+1)'(dx_s);
    dy_a = dy_s[CTR_W] ? (CTR_W+1)'(-dy_s) : (CTR_W+1)'(dy_s);
    div_t  = {rem_r[DV_W-2:0], lo_r[LO_W-1]};
    div_ge = (div_t >= dden_r);
    sq_bit = SQ_W'(1) << {sqk_r, 1'b0};
    sq_sum = sqr_r + sq_bit;
    conf_raw = (sqr_r >= SQ_W'(fgh_pkg::CONF_ONE)) ? '0
             : {1'b0, fgh_pkg::CONF_ONE} - (CF_W+1)'(sqr_r);
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_C_SQX: begin mul_a = 32'(ax_r);   mul_b = 24'(ax_r); end
      ST_C_SQY: begin mul_a = 32'(ay_r);   mul_b = 24'(ay_r); end
      ST_C_W2:  begin mul_a = 32'(wq_r);   mul_b = 24'(wq_r); end
      ST_C_H2:  begin mul_a = 32'(hq_r);   mul_b = 24'(hq_r); end
      ST_C_NH:  begin mul_a = 32'(nx2_r);  mul_b = 24'(prod_r[21:0]); end
      ST_C_NW:  begin mul_a = 32'(ny2_r);  mul_b = 24'(w2_r); end
      ST_C_WH:  begin mul_a = 32'(w2_r);   mul_b = 24'(h2_r); end
      ST_Q_SQX: begin mul_a = 32'(dx_a);   mul_b = 24'(dx_a); end
      ST_Q_SQY: begin mul_a = 32'(dy_a);   mul_b = 24'(dy_a); end
      ST_Q_R2:  begin mul_a = 32'(rd_r.rad); mul_b = 24'(rd_r.rad); end
      ST_Q_ND:  begin mul_a = 32'(d2_r);   mul_b = 24'(EXP_TABLE_DEPTH); end
      ST_Q_EXP: begin
        mul_a = 32'(rd_r.conf);
        mul_b = 24'(exp_tab[q_r[QB-1:0]]);
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PR_W'(mul_a) * PR_W'(mul_b);
  end

  // Face memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state_r == ST_C_STORE) begin
      face_mem[count_r[IDX_W-1:0]] <= '{cx: cx_r, cy: cy_r, rad: rad_r, conf: conf_r};
    end
    if (state_r == ST_Q_RD) begin
      rd_r <= face_mem[idx_r];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= fgh_pkg::FRAME_W_RST;
      fh_r <= fgh_pkg::FRAME_H_RST;
      en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (fgh_pkg::reg_idx_t'(cfg_index))
        fgh_pkg::REG_FRAME_WIDTH:  fw_r <= cfg_data;
        fgh_pkg::REG_FRAME_HEIGHT: fh_r <= cfg_data;
        fgh_pkg::REG_ENABLE:       en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_CONF;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      peak_r      <= '0;
    end else begin
      // drop the held word once taken, unless a new one is loaded
      if (out_valid_r && !out_stall && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            px_r   <= px_m;
            py_r   <= py_m;
            heat_r <= '0;
            full_r <= 1'b0;
            state_r <= ST_DONE;
            case (fgh_pkg::mode_t'(in_data.mode))
              fgh_pkg::MODE_CLEAR: begin
                count_r <= '0;
                peak_r  <= '0;
              end
              fgh_pkg::MODE_ADD: begin
                if (count_r >= CNT_W'(MAX_FACES)) begin
                  full_r <= 1'b1;
                end else begin
                  ax_r  <= nx_a[11:0];
                  ay_r  <= ny_a[11:0];
                  wq_r  <= fw_e;
                  hq_r  <= fh_e;
                  cx_r  <= CTR_W'(px_m) + CTR_W'(bw_e[SZ_W-1:1]);
                  cy_r  <= CTR_W'(py_m) + CTR_W'(bh_e[SZ_W-1:1]);
                  rad_r <= RAD_W'(bmax) + RAD_W'({bmax, 1'b0});
                  state_r <= ST_C_SQX;
                end
              end
              fgh_pkg::MODE_QUERY: begin
                if (en_r && count_r != '0 && peak_r != '0) begin
                  idx_r   <= '0;
                  best_r  <= '0;
                  state_r <= ST_Q_RD;
                end
              end
              default: ;
            endcase
          end
        end
        // confidence of a new box
        ST_C_SQX: state_r <= ST_C_SQY;
        ST_C_SQY: begin nx2_r <= prod_r[23:0]; state_r <= ST_C_W2; end
        ST_C_W2:  begin ny2_r <= prod_r[23:0]; state_r <= ST_C_H2; end
        ST_C_H2:  begin w2_r  <= prod_r[21:0]; state_r <= ST_C_NH; end
        ST_C_NH:  begin h2_r  <= prod_r[21:0]; state_r <= ST_C_NW; end
        ST_C_NW:  begin numa_r <= prod_r[45:0]; state_r <= ST_C_WH; end
        ST_C_WH: begin
          num_r   <= 47'(numa_r) + 47'(prod_r[45:0]);
          state_r <= ST_C_DEN;
        end
        ST_C_DEN: begin den_r <= prod_r[43:0]; state_r <= ST_C_CHK; end
        ST_C_CHK: begin
          if (num_r >= {1'b0, den_r, 2'b00}) begin
            conf_r  <= fgh_pkg::CONF_FLOOR;
            state_r <= ST_C_STORE;
          end else begin
            rem_r   <= DV_W'(num_r);
            lo_r    <= '0;
            q_r     <= '0;
            dden_r  <= (DV_W'(den_r) << 4) + (DV_W'(den_r) << 3) + DV_W'(den_r);
            cnt_r   <= 5'(fgh_pkg::CONF_DIV_STEPS);
            phase_r <= PH_CONF;
            state_r <= ST_DIV;
          end
        end
        ST_SQ_INIT: begin
          sqv_r   <= q_r[SQ_W-1:0];
          sqr_r   <= '0;
          sqk_r   <= 4'(fgh_pkg::SQRT_TOP);
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          if (sqv_r >= sq_sum) begin
            sqv_r <= sqv_r - sq_sum;
            sqr_r <= (sqr_r >> 1) + sq_bit;
          end else begin
            sqr_r <= sqr_r >> 1;
          end
          if (sqk_r == '0) begin
            state_r <= ST_C_CONF;
          end else begin
            sqk_r <= sqk_r - 4'd1;
          end
        end
        ST_C_CONF: begin
          conf_r  <= (conf_raw < (CF_W+1)'(fgh_pkg::CONF_FLOOR)) ? fgh_pkg::CONF_FLOOR
                   : conf_raw[CF_W-1:0];
          state_r <= ST_C_STORE;
        end
        ST_C_STORE: begin
          if (conf_r > peak_r) begin
            peak_r <= conf_r;
          end
          count_r <= count_r + CNT_W'(1);
          state_r <= ST_DONE;
        end
        // query: one face per pass
        ST_Q_RD:  state_r <= ST_Q_SQX;
        ST_Q_SQX: state_r <= ST_Q_SQY;
        ST_Q_SQY: begin d2_r <= prod_r[24:0]; state_r <= ST_Q_R2; end
        ST_Q_R2: begin
          d2_r    <= d2_r + prod_r[24:0];
          state_r <= ST_Q_ND;
        end
        ST_Q_ND: begin
          qden_r  <= {prod_r[26:0], 1'b0};
          state_r <= ST_Q_DCHK;
        end
        ST_Q_DCHK: begin
          if (28'(d2_r) >= qden_r) begin
            state_r <= ST_Q_NEXT;
          end else begin
            rem_r   <= DV_W'(prod_r >> QB);
            lo_r    <= LO_W'(prod_r[QB-1:0]) << (LO_W - QB);
            q_r     <= '0;
            dden_r  <= DV_W'(qden_r);
            cnt_r   <= 5'(QB);
            phase_r <= PH_EXP;
            state_r <= ST_DIV;
          end
        end
        ST_Q_EXP: state_r <= ST_Q_CMP;
        ST_Q_CMP: begin
          if (prod_r[BEST_W-1:0] > best_r) begin
            best_r <= prod_r[BEST_W-1:0];
          end
          state_r <= ST_Q_NEXT;
        end
        ST_Q_NEXT: begin
          if (CNT_W'(idx_r) + CNT_W'(1) == count_r) begin
            rem_r   <= DV_W'(best_r >> fgh_pkg::HEAT_DIV_STEPS);
            lo_r    <= LO_W'(best_r[fgh_pkg::HEAT_DIV_STEPS-1:0])
                       << (LO_W - fgh_pkg::HEAT_DIV_STEPS);
            q_r     <= '0;
            dden_r  <= DV_W'(peak_r);
            cnt_r   <= 5'(fgh_pkg::HEAT_DIV_STEPS);
            phase_r <= PH_HEAT;
            state_r <= ST_DIV;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= ST_Q_RD;
          end
        end
        ST_F_SAT: begin
          heat_r  <= (q_r > LO_W'(fgh_pkg::HEAT_MAX)) ? fgh_pkg::HEAT_MAX
                   : q_r[fgh_pkg::HEAT_W-1:0];
          state_r <= ST_DONE;
        end
        // shared restoring divider, one quotient bit per cycle
        ST_DIV: begin
          rem_r <= div_ge ? (div_t - dden_r) : div_t;
          lo_r  <= lo_r << 1;
          q_r   <= {q_r[LO_W-2:0], div_ge};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            case (phase_r)
              PH_CONF: state_r <= ST_SQ_INIT;
              PH_EXP:  state_r <= ST_Q_EXP;
              PH_HEAT: state_r <= ST_F_SAT;
              default: state_r <= ST_IDLE;
            endcase
          end
        end
        // hold until the output register is free
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r           <= 1'b1;
            out_data_r.heat       <= heat_r;
            out_data_r.face_count <= fgh_pkg::FCNT_W'(count_r);
            out_data_r.list_full  <= full_r;
            state_r               <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/face_gaussian_heatmap_tb.sv =====
module face_gaussian_heatmap_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FACE_SLOTS = 16;
  localparam int LUT_DEPTH  = 256;
  localparam int CYCLE_LIMIT = 2_000_000;

  // DUT ports; every input starts at a known value
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  fgh_pkg::in_word_t  in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  fgh_pkg::out_word_t out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = fgh_pkg::REG_FRAME_WIDTH;
  logic [fgh_pkg::SIZE_W-1:0] cfg_data = '0;

  face_gaussian_heatmap uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the block's state and registers
  longint unsigned gauss_lut[LUT_DEPTH];
  longint          face_x[FACE_SLOTS];
  longint          face_y[FACE_SLOTS];
  longint          face_rad4[FACE_SLOTS];
  longint          face_conf[FACE_SLOTS];
  int              face_total;
  longint          peak_conf;
  int              frame_w;
  int              frame_h;
  int              heat_enable;

  fgh_pkg::out_word_t expected_words[$];
  int        err_cnt;
  int        send_gap_pct;
  int        stall_pct;
  longint    cycle_cnt;

  initial begin
    forever #5 clk = ~clk;
  end

  // exp(-f) for f in Q1.31, 0 <= f <= 1, alternating series through the 16th power
  function automatic longint unsigned neg_exp_frac(longint unsigned f);
    longint unsigned sum;
    longint unsigned term;
    sum  = 64'd1 << 31;
    term = 64'd1 << 31;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * f) >> 31) / longint'(n);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic void build_gauss_lut();
    longint unsigned e1;
    longint unsigned x;
    longint unsigned ip;
    longint unsigned fp;
    longint unsigned ei;
    longint unsigned v;
    e1 = neg_exp_frac(64'd1 << 31);
    for (int k = 0; k < LUT_DEPTH; k++) begin
      x  = ((longint'(k) * 16) << 31) / LUT_DEPTH;
      ip = x >> 31;
      fp = x & ((64'd1 << 31) - 1);
      ei = 64'd1 << 31;
      for (longint unsigned j = 0; j < ip; j++) begin
        ei = (ei * e1) >> 31;
      end
      v = (ei * neg_exp_frac(fp)) >> 31;
      gauss_lut[k] = (v + (64'd1 << 14)) >> 15;
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Confidence falls off with distance from frame center, floored at 0.6
  function automatic longint center_confidence(longint x, longint y, longint bw, longint bh);
    longint w;
    longint h;
    longint nx;
    longint ny;
    longint unsigned num;
    longint unsigned den;
    longint unsigned dv;
    longint unsigned r;
    longint unsigned q;
    longint unsigned v;
    longint c;
    w   = (frame_w != 0) ? frame_w : 1;
    h   = (frame_h != 0) ? frame_h : 1;
    nx  = 2 * x + bw - 2 * (w / 2);
    ny  = 2 * y + bh - 2 * (h / 2);
    num = nx * nx * h * h + ny * ny * w * w;
    den = w * w * h * h;
    if (num >= 4 * den) return longint'(fgh_pkg::CONF_FLOOR);
    dv = 25 * den;
    r  = num;
    q  = 0;
    for (int i = 0; i < 30; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= dv) begin
        r = r - dv;
        q = q | 1;
      end
    end
    v = int_sqrt(q);
    c = (v >= 32768) ? 0 : 32768 - longint'(v);
    return (c < longint'(fgh_pkg::CONF_FLOOR)) ? longint'(fgh_pkg::CONF_FLOOR) : c;
  endfunction

  function automatic longint unsigned heat_at_pixel(longint px, longint py);
    longint unsigned best;
    longint unsigned d2;
    longint unsigned idx;
    longint unsigned e;
    longint unsigned val;
    longint unsigned hv;
    longint dx;
    longint dy;
    if (heat_enable == 0 || face_total == 0 || peak_conf == 0) return 0;
    best = 0;
    for (int i = 0; i < face_total; i++) begin
      dx  = px - face_x[i];
      dy  = py - face_y[i];
      d2  = dx * dx + dy * dy;
      idx = d2 * LUT_DEPTH / (2 * face_rad4[i] * face_rad4[i]);
      e   = (idx < LUT_DEPTH) ? gauss_lut[idx] : 0;
      val = face_conf[i] * e;
      if (val > best) best = val;
    end
    hv = best / peak_conf;
    return (hv > 65535) ? 65535 : hv;
  endfunction

  // Apply one accepted word to the shadow state and return its result
  function automatic fgh_pkg::out_word_t predict_heat_word(fgh_pkg::in_word_t w);
    fgh_pkg::out_word_t res;
    longint bw;
    longint bh;
    longint c;
    res = '0;
    bw = (w.box_width == 0) ? 1 : longint'(w.box_width);
    bh = (w.box_height == 0) ? 1 : longint'(w.box_height);
    case (fgh_pkg::mode_t'(w.mode))
      fgh_pkg::MODE_CLEAR: begin
        face_total = 0;
        peak_conf  = 0;
      end
      fgh_pkg::MODE_ADD: begin
        if (face_total >= FACE_SLOTS) begin
          res.list_full = 1'b1;
        end else begin
          c = center_confidence(longint'(w.pos_x), longint'(w.pos_y), bw, bh);
          face_x[face_total]    = longint'(w.pos_x) + bw / 2;
          face_y[face_total]    = longint'(w.pos_y) + bh / 2;
          face_rad4[face_total] = 3 * ((bw > bh) ? bw : bh);
          face_conf[face_total] = c;
          if (c > peak_conf) peak_conf = c;
          face_total++;
        end
      end
      fgh_pkg::MODE_QUERY: begin
        res.heat = fgh_pkg::HEAT_W'(heat_at_pixel(longint'(w.pos_x), longint'(w.pos_y)));
      end
      default: ;
    endcase
    res.face_count = fgh_pkg::FCNT_W'(face_total);
    return res;
  endfunction

  // Receiver: stall at the configured rate, changing at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Check every accepted result against the oldest expectation
  always @(posedge clk) begin
    fgh_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: heat %0d count %0d full %0d",
               out_data.heat, out_data.face_count, out_data.list_full);
        err_cnt++;
      end else begin
        want = expected_words.pop_front();
        if (out_data.heat !== want.heat) begin
          $error("heat: expected %0d, got %0d", want.heat, out_data.heat);
          err_cnt++;
        end
        if (out_data.face_count !== want.face_count) begin
          $error("face_count: expected %0d, got %0d", want.face_count, out_data.face_count);
          err_cnt++;
        end
        if (out_data.list_full !== want.list_full) begin
          $error("list_full: expected %0d, got %0d", want.list_full, out_data.list_full);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Drive one word, hold it until accepted, then at the configured rate insert a random gap
  task automatic send_word(fgh_pkg::in_word_t w);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    expected_words = {expected_words, predict_heat_word(w)};
    if ($urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  // Registers are written only with the block idle
  task automatic write_reg(fgh_pkg::reg_idx_t idx, int value);
    wait_results_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= fgh_pkg::SIZE_W'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fgh_pkg::REG_FRAME_WIDTH:  frame_w = value & 'h7FF;
      fgh_pkg::REG_FRAME_HEIGHT: frame_h = value & 'h7FF;
      fgh_pkg::REG_ENABLE:       heat_enable = value & 1;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic fgh_pkg::in_word_t make_word(fgh_pkg::mode_t m, int x, int y,
                                                  int bw, int bh);
    fgh_pkg::in_word_t w;
    w.mode       = m;
    w.pos_x      = fgh_pkg::POS_W'(x);
    w.pos_y      = fgh_pkg::POS_W'(y);
    w.box_width  = fgh_pkg::SIZE_W'(bw);
    w.box_height = fgh_pkg::SIZE_W'(bh);
    return w;
  endfunction

  // Mostly modest boxes, sometimes anything the field holds
  function automatic int rand_box_size();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 120);
    if (pick < 95) return $urandom_range(1, 1023);
    return $urandom_range(0, 2047);
  endfunction

  // Queries mostly land near a stored face so the heat is non-trivial
  function automatic fgh_pkg::in_word_t rand_heat_word();
    int pick;
    int i;
    int off;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      return make_word(fgh_pkg::MODE_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 2047), $urandom_range(0, 2047));
    end
    if (pick < 9) begin
      return make_word(fgh_pkg::MODE_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(0, 2047), $urandom_range(0, 2047));
    end
    if (pick < 40) begin
      return make_word(fgh_pkg::MODE_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                       rand_box_size(), rand_box_size());
    end
    if (face_total > 0 && $urandom_range(0, 99) < 75) begin
      i   = $urandom_range(0, face_total - 1);
      off = int'(face_rad4[i]) / 3 + 1;
      return make_word(fgh_pkg::MODE_QUERY,
                       int'(face_x[i]) + $urandom_range(0, 2 * off) - off,
                       int'(face_y[i]) + $urandom_range(0, 2 * off) - off,
                       $urandom_range(0, 2047), $urandom_range(0, 2047));
    end
    return make_word(fgh_pkg::MODE_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 2047), $urandom_range(0, 2047));
  endfunction

  // Corner cases: empty list, unused mode, degenerate and huge boxes,
  // extreme pixels, filling the list and overflowing it
  task automatic test_directed();
    send_gap_pct = 0;
    stall_pct    = 0;
    send_word(make_word(fgh_pkg::MODE_QUERY, 160, 120, 1, 1));
    send_word(make_word(fgh_pkg::MODE_NONE, 1023, 1023, 2047, 2047));
    send_word(make_word(fgh_pkg::MODE_ADD, 0, 0, 0, 0));
    send_word(make_word(fgh_pkg::MODE_ADD, 1023, 1023, 2047, 2047));
    send_word(make_word(fgh_pkg::MODE_ADD, 140, 100, 40, 40));
    send_word(make_word(fgh_pkg::MODE_QUERY, 160, 120, 0, 0));
    send_word(make_word(fgh_pkg::MODE_QUERY, 0, 0, 0, 0));
    send_word(make_word(fgh_pkg::MODE_QUERY, 1023, 1023, 2047, 2047));
    // hold off until the list is settled before filling it
    wait_results_drained();
    for (int k = 0; k < 13; k++) begin
      send_word(make_word(fgh_pkg::MODE_ADD, $urandom_range(0, 1023),
                          $urandom_range(0, 1023), rand_box_size(), rand_box_size()));
    end
    send_word(make_word(fgh_pkg::MODE_ADD, 10, 10, 30, 30));
    send_word(make_word(fgh_pkg::MODE_QUERY, 25, 25, 0, 0));
    send_word(make_word(fgh_pkg::MODE_CLEAR, 0, 0, 0, 0));
    send_word(make_word(fgh_pkg::MODE_QUERY, 25, 25, 0, 0));
  endtask

  // Disabled heat still lets the list change; odd frame sizes
  task automatic test_config_extremes();
    write_reg(fgh_pkg::REG_ENABLE, 0);
    send_word(make_word(fgh_pkg::MODE_ADD, 100, 100, 50, 60));
    send_word(make_word(fgh_pkg::MODE_QUERY, 125, 130, 0, 0));
    write_reg(fgh_pkg::REG_ENABLE, 1);
    send_word(make_word(fgh_pkg::MODE_QUERY, 125, 130, 0, 0));
    write_reg(fgh_pkg::REG_FRAME_WIDTH, 0);
    write_reg(fgh_pkg::REG_FRAME_HEIGHT, 2047);
    send_word(make_word(fgh_pkg::MODE_ADD, 0, 1023, 1, 1024));
    send_word(make_word(fgh_pkg::MODE_QUERY, 0, 1023, 0, 0));
  endtask

  // One random phase under a given frame setting and idling pattern
  task automatic test_random_phase(int fw, int fh, int en, int gap_pct, int st_pct, int count);
    write_reg(fgh_pkg::REG_FRAME_WIDTH, fw);
    write_reg(fgh_pkg::REG_FRAME_HEIGHT, fh);
    write_reg(fgh_pkg::REG_ENABLE, en);
    send_gap_pct = gap_pct;
    stall_pct    = st_pct;
    for (int k = 0; k < count; k++) begin
      send_word(rand_heat_word());
      if ($urandom_range(0, 99) == 0) wait_results_drained();
    end
  endtask

  initial begin
    err_cnt      = 0;
    face_total   = 0;
    peak_conf    = 0;
    frame_w      = 320;
    frame_h      = 240;
    heat_enable  = 1;
    send_gap_pct = 0;
    stall_pct    = 0;
    build_gauss_lut();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_config_extremes();
    test_random_phase(320, 240, 1, 0, 0, 120);
    test_random_phase(1024, 1024, 1, 47, 0, 120);
    test_random_phase(1, 1, 1, 0, 47, 110);
    test_random_phase(640, 480, 0, 25, 25, 60);
    test_random_phase(2047, 3, 1, 25, 25, 110);
    test_random_phase(320, 240, 1, 0, 0, 60);

    wait_results_drained();
    repeat (50) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected result words never arrived", expected_words.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fgh_pkg.sv
hw/rtl/face_gaussian_heatmap.sv
tb/face_gaussian_heatmap_tb.sv
